@@ hdl/fndc_pkg.sv @@
// ----------------------------------------------------------------------------
// fndc_pkg
// Shared types and constants for the fractional-N divider calculator.
// ----------------------------------------------------------------------------
package fndc_pkg;

  localparam int unsigned FreqW  = 56;
  localparam int unsigned FracFp = 24;
  localparam int unsigned DivW   = 27;
  localparam int unsigned IntW   = 8;
  localparam int unsigned FracW  = 10;

  // Frequency limits and band edges in 32.24 fixed-point hertz
  localparam logic [FreqW-1:0] FREQ_MIN_FP  = 56'(64'd2000 * 64'd1000000) << FracFp;
  localparam logic [FreqW-1:0] FREQ_MAX_FP  = 56'(64'd3000 * 64'd1000000) << FracFp;
  localparam logic [FreqW-1:0] EDGE_2400_FP = 56'(64'd2400 * 64'd1000000) << FracFp;
  localparam logic [FreqW-1:0] EDGE_2500_FP = 56'(64'd2500 * 64'd1000000) << FracFp;
  localparam logic [FreqW-1:0] EDGE_2600_FP = 56'(64'd2600 * 64'd1000000) << FracFp;

  // div = floor((f + 240e6) / 2^11 / 234375): VCO scale, rounding term and
  // 30 MHz step folded into one constant divide
  localparam logic [FreqW-1:0] ROUND_OFS = 56'd240000000;
  localparam logic [17:0]      DIV_D     = 18'd234375;
  // floor(2^49 / 234375): reciprocal for the top 32 bits of the sum
  localparam logic [31:0]      RECIP_M   = 32'd2401919801;
  // 30e6 * 16: hertz per divider step
  localparam logic [28:0]      TUNE_STEP = 29'd480000000;

  localparam logic [1:0] LO_BAND_0 = 2'd0;
  localparam logic [1:0] LO_BAND_1 = 2'd1;
  localparam logic [1:0] LO_BAND_2 = 2'd2;
  localparam logic [1:0] LO_BAND_3 = 2'd3;

  typedef struct packed {
    logic [1:0] lo_band;
    logic       front_band;
  } band_t;

endpackage

@@ hdl/fndc_clamp.sv @@
// ----------------------------------------------------------------------------
// fndc_clamp
// Saturates the requested frequency and decodes the LO and front-end bands.
// ----------------------------------------------------------------------------
module fndc_clamp (
  input  logic [fndc_pkg::FreqW-1:0] freq,
  output logic [fndc_pkg::FreqW-1:0] freq_sat,
  output fndc_pkg::band_t            band
);
  import fndc_pkg::*;

  always_comb begin
    if (freq > FREQ_MAX_FP) begin
      freq_sat = FREQ_MAX_FP;
    end else if (freq < FREQ_MIN_FP) begin
      freq_sat = FREQ_MIN_FP;
    end else begin
      freq_sat = freq;
    end
  end

  always_comb begin
    if (freq_sat < EDGE_2400_FP) begin
      band.lo_band = LO_BAND_0;
    end else if (freq_sat < EDGE_2500_FP) begin
      band.lo_band = LO_BAND_1;
    end else if (freq_sat < EDGE_2600_FP) begin
      band.lo_band = LO_BAND_2;
    end else begin
      band.lo_band = LO_BAND_3;
    end
    band.front_band = (freq_sat >= EDGE_2500_FP);
  end

endmodule

@@ hdl/fractional_n_divider_calc_unit.sv @@
// ----------------------------------------------------------------------------
// fractional_n_divider_calc_unit
// Fractional-N synthesizer divider words and tuned frequency from a request.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one beat per request: in_req_freq (unsigned
//   32.24 hertz) and in_program_req. The result channel returns one beat per
//   request, in order: LO and front-end band indexes, the 8-bit integer
//   divider, the two 10-bit fraction words, the tuned frequency and the
//   apply flag. The request is saturated to 2000..3000 MHz before any other
//   step. The pipeline has six register stages. Throughput is one beat per
//   cycle while the receiver does not stall; the stage count is set by
//   the constant divide, done as a 32x32 reciprocal multiply, a 27x18
//   remainder multiply and a one-step correction, plus the 27x29
//   tuned-frequency multiply in front of the output register.
//   When the receiver stalls, the output beat holds and earlier stages keep
//   filling bubbles; in_stall rises only once every stage holds a beat.
//   Reset empties the pipeline; the block accepts a beat the cycle after.
// ----------------------------------------------------------------------------
module fractional_n_divider_calc_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fndc_pkg::FreqW-1:0]        in_req_freq,
  input  logic                              in_program_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_lo_band,
  output logic                              out_front_band,
  output logic [fndc_pkg::IntW-1:0]         out_int_div,
  output logic [fndc_pkg::FracW-1:0]        out_frac_high,
  output logic [fndc_pkg::FracW-1:0]        out_frac_low,
  output logic [fndc_pkg::FreqW-1:0]        out_tuned_freq,
  output logic                              out_apply
);
  import fndc_pkg::*;

  // Stage valid bits
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, out_valid_r;
  logic s1_v_nxt, s2_v_nxt, s3_v_nxt, s4_v_nxt, s5_v_nxt, out_valid_nxt;
  // Per-stage load enables: a stage loads when empty or when it drains
  logic rdy1, rdy2, rdy3, rdy4, rdy5, out_rdy;

  // Stage 1: captured request
  logic [FreqW-1:0] s1_freq_r;
  logic             s1_prog_r;

  // Stage 2: saturated, banded, offset sum split for the divide
  logic [FreqW-1:0] freq_sat;
  band_t            band;
  logic [FreqW-1:0] sum;
  band_t            s2_band_r;
  logic             s2_prog_r;
  logic [19:0]      s2_ylo_r;
  logic [31:0]      s2_yt_r;

  // Stage 3: quotient estimate (never high, at most one low)
  logic [63:0]      recip_prod;
  band_t            s3_band_r;
  logic             s3_prog_r;
  logic [19:0]      s3_ylo_r;
  logic [DivW-1:0]  s3_q_r;

  // Stage 4: low bits of quotient times divisor
  logic [44:0]      qd_prod;
  band_t            s4_band_r;
  logic             s4_prog_r;
  logic [19:0]      s4_ylo_r;
  logic [DivW-1:0]  s4_q_r;
  logic [19:0]      s4_qdlo_r;

  // Stage 5: corrected divider
  logic [19:0]      rem;
  logic [DivW-1:0]  div_fix;
  band_t            s5_band_r;
  logic             s5_prog_r;
  logic [DivW-1:0]  s5_div_r;

  // Output register
  logic [FreqW-1:0] tuned_prod;
  band_t            out_band_r;
  logic             out_apply_r;
  logic [DivW-1:0]  out_div_r;
  logic [FreqW-1:0] out_tuned_r;

  // Ready chain, from the receiver back to the input
  assign out_rdy  = !out_valid_r || !out_stall;
  assign rdy5     = !s5_v_r || out_rdy;
  assign rdy4     = !s4_v_r || rdy5;
  assign rdy3     = !s3_v_r || rdy4;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_stall = !rdy1;

  assign s1_v_nxt      = rdy1    ? in_valid : s1_v_r;
  assign s2_v_nxt      = rdy2    ? s1_v_r   : s2_v_r;
  assign s3_v_nxt      = rdy3    ? s2_v_r   : s3_v_r;
  assign s4_v_nxt      = rdy4    ? s3_v_r   : s4_v_r;
  assign s5_v_nxt      = rdy5    ? s4_v_r   : s5_v_r;
  assign out_valid_nxt = out_rdy ? s5_v_r   : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      s3_v_r      <= s3_v_nxt;
      s4_v_r      <= s4_v_nxt;
      s5_v_r      <= s5_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Saturate and decode bands
  fndc_clamp u_clamp (
    .freq     (s1_freq_r),
    .freq_sat (freq_sat),
    .band     (band)
  );

  // (f + 240e6) >> 11 is the dividend; its top 32 bits feed the reciprocal
  // and its low 20 bits feed the remainder check
  assign sum        = freq_sat + ROUND_OFS;
  assign recip_prod = 64'(s2_yt_r) * 64'(RECIP_M);
  assign qd_prod    = 45'(s3_q_r) * 45'(DIV_D);
  // Remainder is below twice the divisor, so 20 bits wrap cleanly
  assign rem        = s4_ylo_r - s4_qdlo_r;
  assign div_fix    = s4_q_r + DivW'(rem >= 20'(DIV_D));
  assign tuned_prod = 56'(s5_div_r) * 56'(TUNE_STEP);

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_freq_r <= in_req_freq;
      s1_prog_r <= in_program_req;
    end
    if (rdy2 && s1_v_r) begin
      s2_band_r <= band;
      s2_prog_r <= s1_prog_r;
      s2_ylo_r  <= sum[30:11];
      s2_yt_r   <= sum[55:24];
    end
    if (rdy3 && s2_v_r) begin
      s3_band_r <= s2_band_r;
      s3_prog_r <= s2_prog_r;
      s3_ylo_r  <= s2_ylo_r;
      s3_q_r    <= recip_prod[62:36];
    end
    if (rdy4 && s3_v_r) begin
      s4_band_r <= s3_band_r;
      s4_prog_r <= s3_prog_r;
      s4_ylo_r  <= s3_ylo_r;
      s4_q_r    <= s3_q_r;
      s4_qdlo_r <= qd_prod[19:0];
    end
    if (rdy5 && s4_v_r) begin
      s5_band_r <= s4_band_r;
      s5_prog_r <= s4_prog_r;
      s5_div_r  <= div_fix;
    end
    if (out_rdy && s5_v_r) begin
      out_band_r  <= s5_band_r;
      out_apply_r <= s5_prog_r;
      out_div_r   <= s5_div_r;
      out_tuned_r <= tuned_prod;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_lo_band    = out_band_r.lo_band;
  assign out_front_band = out_band_r.front_band;
  assign out_int_div    = {1'b0, out_div_r[DivW-1:20]};
  assign out_frac_high  = out_div_r[19:10];
  assign out_frac_low   = out_div_r[9:0];
  assign out_tuned_freq = out_tuned_r;
  assign out_apply      = out_apply_r;

  // The front-end band follows the upper LO band bit
  a_front_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_front_band == out_lo_band[1]))
    else $error("front-end band disagrees with LO band");

  // Saturated input keeps the integer divider within 66..100
  a_int_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_int_div >= 8'd66 && out_int_div <= 8'd100))
    else $error("integer divider out of range");

  // Reciprocal estimate is off by at most one step
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (rem < 20'(2 * 234375)))
    else $error("quotient estimate off by more than one");

  // Stall the input only when the whole pipeline is full and held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s5_v_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule
